### hw/rtl/mgv_pkg.sv
// mgv_pkg: shared constants for the staggered velocity grid tracer
// no dependencies; imported by mac_grid_velocity_trace and mgv_interp
`timescale 1ns / 1ps

package mgv_pkg;

    // default grid geometry and fixed-point format
    localparam int DEF_SIZE_X    = 64;
    localparam int DEF_SIZE_Y    = 64;
    localparam int DEF_SIZE_Z    = 64;
    localparam int DEF_FRAC_BITS = 16;

    // field widths
    localparam int VAL_W   = 32;
    localparam int POSIN_W = 24;
    localparam int CELL_W  = 6;
    localparam int STEP_W  = 18;
    // internal position width, holds the unsaturated midpoint
    localparam int POS_W   = 48;

    localparam logic [STEP_W-1:0] STEP_RESET = 18'd1638;

    // stream widths
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 96;

    // opcodes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_TRACE  = 2'd2;

    // velocity components
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    // result kinds
    localparam logic KIND_VEL = 1'b0;
    localparam logic KIND_POS = 1'b1;

endpackage

### hw/rtl/mac_grid_velocity_trace.sv
// mac_grid_velocity_trace: top level of the staggered velocity grid sampler and tracer
// depends on mgv_pkg, mgv_ram and mgv_interp
`timescale 1ns / 1ps

// Usage
// Input stream (s_): one transfer per operation, opcode in s_tuser.
//   write: stores one velocity component of one cell, no result transfer.
//   sample: returns the staggered trilinear velocity at pos (m_tuser = 0).
//   trace: returns the midpoint-traced position (m_tuser = 1).
// Output stream (m_): one registered result transfer per sample or trace.
// Timing: one item in flight. Each velocity component is evaluated in order:
// start, corner reads from the single RAM read port, seven lerps on one shared
// multiplier, done. A sample gives its result after its three components; a
// trace runs two velocity evaluations plus two sets of three timestep products
// before its result. The next item is taken only once the result is loaded.
// Reset: a clearing pass zeroes the velocity RAM, one word per cycle, over all
// 3*SIZE_X*SIZE_Y*SIZE_Z words (786432 at the default size); s_tready stays
// low during it. step_time returns to 1638 and may be written at any time.
// Stalls: while m_tready is low the result holds in the output register;
// the next item is still accepted and runs until its own result is due.

module mac_grid_velocity_trace
    import mgv_pkg::*;
#(
    parameter int SIZE_X    = DEF_SIZE_X,
    parameter int SIZE_Y    = DEF_SIZE_Y,
    parameter int SIZE_Z    = DEF_SIZE_Z,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [STEP_W-1:0]      cfg_wr_data,   // step_time
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // cell_x[5:0] cell_y[11:6] cell_z[17:12] component[19:18] write_value[51:20]
    // pos_x[75:52] pos_y[99:76] pos_z[123:100] backward[124], zero above
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]             s_tuser,       // opcode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // res_x[31:0] res_y[63:32] res_z[95:64]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser        // result_kind
);

    localparam int DEPTH = 3 * SIZE_X * SIZE_Y * SIZE_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = STEP_W + 1 + VAL_W;
    localparam logic signed [MW-1:0] RND_MID = MW'(1) << FRAC_BITS;
    localparam logic signed [MW-1:0] RND_FIN = MW'(1) << (FRAC_BITS - 1);
    localparam logic signed [POS_W-1:0] SAT_MAX = POS_W'(32'h7FFF_FFFF);
    localparam logic signed [POS_W-1:0] SAT_MIN = -SAT_MAX - POS_W'(1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_VSTART = 3'd2;
    localparam logic [2:0] ST_VWAIT  = 3'd3;
    localparam logic [2:0] ST_SMUL   = 3'd4;
    localparam logic [2:0] ST_SADD   = 3'd5;
    localparam logic [2:0] ST_OUTPUT = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     clr_reg;
    logic [1:0]        cc_reg;
    logic              pass_reg;
    logic              kind_reg;
    logic              back_reg;
    logic [STEP_W-1:0] step_reg;
    logic              mval_reg;
    logic [OUT_TDATA_W-1:0] mdata_reg;
    logic              mkind_reg;
    logic signed [POS_W-1:0] p_reg   [3];
    logic signed [POS_W-1:0] q_reg   [3];
    logic [VAL_W-1:0]        vel_reg [3];
    logic [VAL_W-1:0]        res_reg [3];
    logic signed [MW-1:0]    mul_reg;

    // input fields
    logic [1:0]        in_op;
    logic [CELL_W-1:0] in_cx, in_cy, in_cz;
    logic [1:0]        in_comp;
    logic [VAL_W-1:0]  in_wval;
    logic accept, wr_ok, out_free;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr, wr_addr;
    logic [VAL_W-1:0]  ram_wdata, ram_rdata;
    logic              ip_start, ip_done;
    logic [VAL_W-1:0]  ip_value;

    logic signed [STEP_W:0]  t_s;
    logic signed [MW-1:0]    rnd_mid, rnd_fin;
    logic signed [POS_W-1:0] fin_sum;
    logic [VAL_W-1:0]        fin_sat;

    assign in_op    = s_tuser;
    assign in_cx    = s_tdata[5:0];
    assign in_cy    = s_tdata[11:6];
    assign in_cz    = s_tdata[17:12];
    assign in_comp  = s_tdata[19:18];
    assign in_wval  = s_tdata[51:20];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !mval_reg || m_tready;

    // write path: drop bad component or cell beyond the grid
    assign wr_ok = (in_comp != 2'd3) && (32'(in_cx) < SIZE_X) && (32'(in_cy) < SIZE_Y)
                && (32'(in_cz) < SIZE_Z);
    assign wr_addr = AW'((((AW'(in_cz) * AW'(SIZE_Y) + AW'(in_cy)) * AW'(SIZE_X)
                     + AW'(in_cx)) * AW'(3)) + AW'(in_comp));

    // RAM write port shared by the clearing pass and write items
    always_comb begin
        ram_we    = (state_reg == ST_CLEAR) || (accept && (in_op == OP_WRITE) && wr_ok);
        ram_waddr = (state_reg == ST_CLEAR) ? clr_reg : wr_addr;
        ram_wdata = (state_reg == ST_CLEAR) ? '0 : in_wval;
    end

    mgv_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ip_start = (state_reg == ST_VSTART);

    mgv_interp #(
        .SIZE_X    (SIZE_X),
        .SIZE_Y    (SIZE_Y),
        .SIZE_Z    (SIZE_Z),
        .FRAC_BITS (FRAC_BITS),
        .AW        (AW)
    ) u_interp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ip_start),
        .comp    (cc_reg),
        .pos_x   (pass_reg ? q_reg[0] : p_reg[0]),
        .pos_y   (pass_reg ? q_reg[1] : p_reg[1]),
        .pos_z   (pass_reg ? q_reg[2] : p_reg[2]),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata),
        .done    (ip_done),
        .value   (ip_value)
    );

    // timestep scaling and final saturation
    always_comb begin
        t_s     = back_reg ? -$signed({1'b0, step_reg}) : $signed({1'b0, step_reg});
        rnd_mid = (mul_reg + RND_MID) >>> (FRAC_BITS + 1);
        rnd_fin = (mul_reg + RND_FIN) >>> FRAC_BITS;
        fin_sum = p_reg[cc_reg] + rnd_fin[POS_W-1:0];
        if (fin_sum > SAT_MAX) begin
            fin_sat = SAT_MAX[VAL_W-1:0];
        end else if (fin_sum < SAT_MIN) begin
            fin_sat = SAT_MIN[VAL_W-1:0];
        end else begin
            fin_sat = fin_sum[VAL_W-1:0];
        end
    end

    // operation sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && (in_op == OP_SAMPLE || in_op == OP_TRACE)) begin
                    state_next = ST_VSTART;
                end
            end
            ST_VSTART: begin
                state_next = ST_VWAIT;
            end
            ST_VWAIT: begin
                if (ip_done) begin
                    if (cc_reg != COMP_Z) begin
                        state_next = ST_VSTART;
                    end else if (kind_reg == KIND_VEL) begin
                        state_next = ST_OUTPUT;
                    end else begin
                        state_next = ST_SMUL;
                    end
                end
            end
            ST_SMUL: begin
                state_next = ST_SADD;
            end
            ST_SADD: begin
                if (cc_reg != COMP_Z) begin
                    state_next = ST_SMUL;
                end else if (!pass_reg) begin
                    state_next = ST_VSTART;
                end else begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            cc_reg    <= COMP_X;
            pass_reg  <= 1'b0;
            step_reg  <= STEP_RESET;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (cfg_wr_en) begin
                step_reg <= cfg_wr_data;
            end
            if (state_reg == ST_IDLE) begin
                cc_reg   <= COMP_X;
                pass_reg <= 1'b0;
            end
            if ((state_reg == ST_VWAIT && ip_done) || state_reg == ST_SADD) begin
                cc_reg <= (cc_reg == COMP_Z) ? COMP_X : cc_reg + 2'd1;
            end
            if (state_reg == ST_SADD && cc_reg == COMP_Z) begin
                pass_reg <= 1'b1;
            end
            if (state_reg == ST_OUTPUT && out_free) begin
                mval_reg <= 1'b1;
            end else if (m_tready) begin
                mval_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= (in_op == OP_TRACE) ? KIND_POS : KIND_VEL;
            back_reg <= s_tdata[124];
            p_reg[0] <= POS_W'($signed(s_tdata[75:52]));
            p_reg[1] <= POS_W'($signed(s_tdata[99:76]));
            p_reg[2] <= POS_W'($signed(s_tdata[123:100]));
        end
        if (state_reg == ST_VWAIT && ip_done) begin
            vel_reg[cc_reg] <= ip_value;
        end
        if (state_reg == ST_SMUL) begin
            mul_reg <= t_s * $signed(vel_reg[cc_reg]);
        end
        if (state_reg == ST_SADD) begin
            if (!pass_reg) begin
                q_reg[cc_reg] <= p_reg[cc_reg] + rnd_mid[POS_W-1:0];
            end else begin
                res_reg[cc_reg] <= fin_sat;
            end
        end
        if (state_reg == ST_OUTPUT && out_free) begin
            mkind_reg <= kind_reg;
            if (kind_reg == KIND_VEL) begin
                mdata_reg <= {vel_reg[2], vel_reg[1], vel_reg[0]};
            end else begin
                mdata_reg <= {res_reg[2], res_reg[1], res_reg[0]};
            end
        end
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = mkind_reg;

    // no item is taken while the clearing pass runs
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input accepted during clearing pass");

    // interpolation results arrive only while the sequencer waits for them
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        ip_done |-> (state_reg == ST_VWAIT))
        else $error("interpolation finished outside wait state");

    // RAM writes never overlap a velocity evaluation
    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_IDLE))
        else $error("RAM write during evaluation");

    // a result loaded when the output register is free is presented on m_tvalid
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUTPUT && out_free) |=> m_tvalid)
        else $error("result not presented");

endmodule

### hw/rtl/mgv_ram.sv
// mgv_ram: generic simple dual-port RAM, one write and one registered read
// no dependencies
`timescale 1ns / 1ps

module mgv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/mgv_interp.sv
// mgv_interp: trilinear interpolation of one staggered velocity component
// fetches eight corners from the velocity RAM, then runs seven lerps on one multiplier
// depends on mgv_pkg
`timescale 1ns / 1ps

module mgv_interp
    import mgv_pkg::*;
#(
    parameter int SIZE_X    = DEF_SIZE_X,
    parameter int SIZE_Y    = DEF_SIZE_Y,
    parameter int SIZE_Z    = DEF_SIZE_Z,
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int AW        = $clog2(3 * SIZE_X * SIZE_Y * SIZE_Z)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [1:0]              comp,
    input  logic signed [POS_W-1:0] pos_x,
    input  logic signed [POS_W-1:0] pos_y,
    input  logic signed [POS_W-1:0] pos_z,
    output logic                    rd_en,
    output logic [AW-1:0]           rd_addr,
    input  logic [VAL_W-1:0]        rd_data,
    output logic                    done,
    output logic [VAL_W-1:0]        value
);

    localparam int XW = $clog2(SIZE_X);
    localparam int YW = $clog2(SIZE_Y);
    localparam int ZW = $clog2(SIZE_Z);
    localparam int PW = VAL_W + 2 + FRAC_BITS;
    localparam logic signed [POS_W-1:0] HALF_POS = POS_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [PW-1:0]    HALF_P   = PW'(1) << (FRAC_BITS - 1);

    localparam logic [1:0] I_IDLE  = 2'd0;
    localparam logic [1:0] I_FETCH = 2'd1;
    localparam logic [1:0] I_MUL   = 2'd2;
    localparam logic [1:0] I_ADD   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [3:0] fc_reg, fc_next;
    logic [2:0] lk_reg, lk_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       done_reg, done_next;
    logic       inr_reg;
    logic [1:0] comp_reg;
    logic signed [POS_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [FRAC_BITS-1:0]    fx_reg, fy_reg, fz_reg;
    logic [VAL_W-1:0]        que_reg [8];
    logic [VAL_W-1:0]        val_reg;
    logic signed [PW-1:0]    prod_reg;

    logic signed [POS_W-1:0] ox, oy, oz;
    logic signed [POS_W-1:0] ci, cj, ck;
    logic                    inr;
    logic [FRAC_BITS-1:0]    fsel;
    logic signed [VAL_W:0]   diff;
    logic signed [PW-1:0]    rnd;
    logic [VAL_W:0]          lsum;

    function automatic logic [VAL_W:0] rd_sext(input logic [VAL_W-1:0] v);
        rd_sext = {v[VAL_W-1], v};
    endfunction

    // staggered offsets: each component is shifted half a cell on the other axes
    always_comb begin
        ox = (comp == COMP_X) ? pos_x : pos_x - HALF_POS;
        oy = (comp == COMP_Y) ? pos_y : pos_y - HALF_POS;
        oz = (comp == COMP_Z) ? pos_z : pos_z - HALF_POS;
    end

    // corner coordinates and grid bounds for the corner being fetched
    always_comb begin
        ci  = cx_reg + POS_W'(fc_reg[0]);
        cj  = cy_reg + POS_W'(fc_reg[1]);
        ck  = cz_reg + POS_W'(fc_reg[2]);
        inr = (ci >= 0) && (ci < $signed(POS_W'(SIZE_X)))
           && (cj >= 0) && (cj < $signed(POS_W'(SIZE_Y)))
           && (ck >= 0) && (ck < $signed(POS_W'(SIZE_Z)));
        rd_en   = (state_reg == I_FETCH) && (fc_reg < 4'd8);
        rd_addr = AW'((((AW'(ck[ZW-1:0]) * AW'(SIZE_Y) + AW'(cj[YW-1:0])) * AW'(SIZE_X)
                  + AW'(ci[XW-1:0])) * AW'(3)) + AW'(comp_reg));
    end

    // lerp datapath: a + round((b - a) * f)
    always_comb begin
        if (lk_reg < 3'd4) begin
            fsel = fx_reg;
        end else if (lk_reg < 3'd6) begin
            fsel = fy_reg;
        end else begin
            fsel = fz_reg;
        end
        diff = $signed({rd_sext(que_reg[1])}) - $signed({rd_sext(que_reg[0])});
        rnd  = (prod_reg + HALF_P) >>> FRAC_BITS;
        lsum = {que_reg[0][VAL_W-1], que_reg[0]} + rnd[VAL_W:0];
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        fc_next    = fc_reg;
        lk_next    = lk_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            I_IDLE: begin
                if (start) begin
                    state_next = I_FETCH;
                    fc_next    = 4'd0;
                end
            end
            I_FETCH: begin
                fc_next = fc_reg + 4'd1;
                if (fc_reg == 4'd8) begin
                    state_next = I_MUL;
                    lk_next    = 3'd0;
                    cnt_next   = 4'd8;
                end
            end
            I_MUL: begin
                state_next = I_ADD;
            end
            I_ADD: begin
                cnt_next = cnt_reg - 4'd1;
                lk_next  = lk_reg + 3'd1;
                if (lk_reg == 3'd6) begin
                    state_next = I_IDLE;
                    done_next  = 1'b1;
                end else begin
                    state_next = I_MUL;
                end
            end
            default: begin
                state_next = I_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= I_IDLE;
            fc_reg    <= '0;
            lk_reg    <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fc_reg    <= fc_next;
            lk_reg    <= lk_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // payload: split position, corner queue, multiplier and result
    always_ff @(posedge aclk) begin
        if (state_reg == I_IDLE && start) begin
            comp_reg <= comp;
            cx_reg   <= ox >>> FRAC_BITS;
            cy_reg   <= oy >>> FRAC_BITS;
            cz_reg   <= oz >>> FRAC_BITS;
            fx_reg   <= ox[FRAC_BITS-1:0];
            fy_reg   <= oy[FRAC_BITS-1:0];
            fz_reg   <= oz[FRAC_BITS-1:0];
        end
        if (state_reg == I_FETCH) begin
            inr_reg <= inr;
            if (fc_reg != 4'd0) begin
                que_reg[fc_reg[2:0] - 3'd1] <= inr_reg ? rd_data : '0;
            end
        end
        if (state_reg == I_MUL) begin
            prod_reg <= diff * $signed({1'b0, fsel});
        end
        if (state_reg == I_ADD) begin
            // pop the consumed pair, push the lerp result at the tail
            for (int m = 0; m < 6; m++) begin
                que_reg[m] <= (4'(m) == cnt_reg - 4'd2) ? lsum[VAL_W-1:0] : que_reg[m + 2];
            end
            if (cnt_reg == 4'd8) begin
                que_reg[6] <= lsum[VAL_W-1:0];
            end
            val_reg <= lsum[VAL_W-1:0];
        end
    end

    assign done  = done_reg;
    assign value = val_reg;

endmodule
